// ----- hdl/rmp_pkg.sv -----
// shared types and constants of the multibulk request parser
package rmp_pkg;

    // configuration port
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 30;
    localparam int COUNT_LIMIT_W  = 21;
    localparam int LENGTH_LIMIT_W = 30;

    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_LIMIT = 1'd1;

    localparam logic [COUNT_LIMIT_W-1:0]  COUNT_LIMIT_RST  = 21'd1048576;
    localparam logic [LENGTH_LIMIT_W-1:0] LENGTH_LIMIT_RST = 30'd536870912;

    // stream characters
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY_ARG = 2'd1,
        KIND_EMPTY_CMD = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_NOT_MULTIBULK = 2'd1,
        ERR_BAD_NUMBER    = 2'd2
    } err_t;

    // result beat without the argument index
    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       last_in_arg;
        logic       last_in_command;
        err_t       error_code;
    } rslt_t;

endpackage

// ----- hdl/rmp_parse.sv -----
// byte-wise parse state machine with configuration registers
module rmp_parse
    import rmp_pkg::*;
#(
    parameter int ARG_INDEX_BITS = 20,
    parameter int LENGTH_BITS    = 30
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      beat,
    input  logic [7:0]                in_byte,
    output logic                      rslt_valid,
    output rslt_t                     rslt,
    output logic [ARG_INDEX_BITS-1:0] rslt_idx
);

    // effective widths of counts, lengths and the shared number accumulator
    localparam int CNT_W = (ARG_INDEX_BITS < COUNT_LIMIT_W) ? ARG_INDEX_BITS + 1
                                                            : COUNT_LIMIT_W;
    localparam int LEN_W = (LENGTH_BITS < LENGTH_LIMIT_W) ? LENGTH_BITS : LENGTH_LIMIT_W;
    localparam int NUM_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int VAL_W = NUM_W + 4;

    // caps that the index and length widths put on the limit registers
    localparam logic [COUNT_LIMIT_W:0] CNT_CAP = (ARG_INDEX_BITS < COUNT_LIMIT_W)
        ? ((COUNT_LIMIT_W+1)'(1) << ARG_INDEX_BITS) : {(COUNT_LIMIT_W+1){1'b1}};
    localparam logic [LENGTH_LIMIT_W-1:0] LEN_CAP = (LENGTH_BITS < LENGTH_LIMIT_W)
        ? LENGTH_LIMIT_W'(((LENGTH_LIMIT_W+1)'(1) << LENGTH_BITS) - 1)
        : {LENGTH_LIMIT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_LIM_RST =
        ({1'b0, COUNT_LIMIT_RST} > CNT_CAP) ? CNT_W'(CNT_CAP) : CNT_W'(COUNT_LIMIT_RST);
    localparam logic [LEN_W-1:0] LEN_LIM_RST =
        (LENGTH_LIMIT_RST > LEN_CAP) ? LEN_W'(LEN_CAP) : LEN_W'(LENGTH_LIMIT_RST);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DROP,
        PH_COUNT,
        PH_COUNT_LF,
        PH_ARG_LEAD,
        PH_LEN,
        PH_LEN_LF,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    typedef enum logic [1:0] {
        DIG_NONE,
        DIG_ZERO,
        DIG_MORE
    } digit_t;

    phase_t                    phase_reg, phase_next;
    digit_t                    dig_reg, dig_next;
    logic [NUM_W-1:0]          accum_reg, accum_next;
    logic [CNT_W-1:0]          args_reg, args_next;
    logic [ARG_INDEX_BITS-1:0] cur_reg, cur_next;
    logic [LEN_W-1:0]          bytes_reg, bytes_next;
    logic [1:0]                skip_reg, skip_next;
    logic [CNT_W-1:0]          cnt_lim_reg;
    logic [LEN_W-1:0]          len_lim_reg;

    logic                      is_digit;
    logic [3:0]                digit;
    logic [VAL_W-1:0]          value;
    logic [NUM_W-1:0]          limit;
    logic                      num_bad;
    logic                      num_done;
    logic                      last_arg;
    logic [1:0]                skip_dec;

    // limit registers, clamped on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_lim_reg <= CNT_LIM_RST;
            len_lim_reg <= LEN_LIM_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COUNT_LIMIT)
            begin
                if ({1'b0, cfg_data[COUNT_LIMIT_W-1:0]} > CNT_CAP)
                    cnt_lim_reg <= CNT_W'(CNT_CAP);
                else
                    cnt_lim_reg <= CNT_W'(cfg_data[COUNT_LIMIT_W-1:0]);
            end
            if (cfg_index == REG_LENGTH_LIMIT)
            begin
                if (cfg_data[LENGTH_LIMIT_W-1:0] > LEN_CAP)
                    len_lim_reg <= LEN_W'(LEN_CAP);
                else
                    len_lim_reg <= LEN_W'(cfg_data[LENGTH_LIMIT_W-1:0]);
            end
        end
    end

    // decimal digit step: accum * 10 + digit against the active limit
    always_comb
    begin
        is_digit = in_byte inside {[CH_ZERO:CH_NINE]};
        digit    = in_byte[3:0];
        value    = (VAL_W'(accum_reg) << 3) + (VAL_W'(accum_reg) << 1) + VAL_W'(digit);
        limit    = (phase_reg == PH_COUNT) ? NUM_W'(cnt_lim_reg) : NUM_W'(len_lim_reg);
        num_done = (in_byte == CH_CR) && (dig_reg != DIG_NONE);
        if (in_byte == CH_CR)
            num_bad = (dig_reg == DIG_NONE);
        else
            num_bad = !is_digit || (dig_reg == DIG_ZERO) || (value > VAL_W'(limit));
        last_arg = (args_reg == CNT_W'(1));
        skip_dec = (skip_reg != 2'd0) ? skip_reg - 2'd1 : 2'd0;
    end

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        dig_next   = dig_reg;
        accum_next = accum_reg;
        args_next  = args_reg;
        cur_next   = cur_reg;
        bytes_next = bytes_reg;
        skip_next  = skip_reg;
        rslt_valid = 1'b0;
        rslt_idx   = '0;
        rslt       = '{kind: KIND_PAYLOAD, out_byte: 8'd0, last_in_arg: 1'b0,
                       last_in_command: 1'b0, error_code: ERR_NONE};
        if (beat)
        begin
            case (phase_reg)
                PH_IDLE, PH_DROP:
                begin
                    if (in_byte == CH_STAR)
                    begin
                        phase_next = PH_COUNT;
                        accum_next = '0;
                        dig_next   = DIG_NONE;
                        cur_next   = '0;
                        args_next  = '0;
                    end
                    else if (phase_reg == PH_IDLE)
                    begin
                        phase_next      = PH_DROP;
                        rslt_valid      = 1'b1;
                        rslt.kind       = KIND_ERROR;
                        rslt.error_code = ERR_NOT_MULTIBULK;
                    end
                end
                PH_COUNT:
                begin
                    if (num_bad)
                    begin
                        phase_next      = PH_DROP;
                        rslt_valid      = 1'b1;
                        rslt.kind       = KIND_ERROR;
                        rslt.error_code = ERR_BAD_NUMBER;
                    end
                    else if (num_done)
                    begin
                        args_next  = CNT_W'(accum_reg);
                        phase_next = PH_COUNT_LF;
                        if (accum_reg == '0)
                        begin
                            rslt_valid           = 1'b1;
                            rslt.kind            = KIND_EMPTY_CMD;
                            rslt.last_in_command = 1'b1;
                        end
                    end
                    else
                    begin
                        accum_next = NUM_W'(value);
                        dig_next   = (dig_reg == DIG_NONE && digit == 4'd0) ? DIG_ZERO
                                                                             : DIG_MORE;
                    end
                end
                PH_COUNT_LF:
                begin
                    phase_next = (args_reg != '0) ? PH_ARG_LEAD : PH_IDLE;
                end
                PH_ARG_LEAD:
                begin
                    accum_next = '0;
                    dig_next   = DIG_NONE;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (num_bad)
                    begin
                        phase_next      = PH_DROP;
                        rslt_valid      = 1'b1;
                        rslt_idx        = cur_reg;
                        rslt.kind       = KIND_ERROR;
                        rslt.error_code = ERR_BAD_NUMBER;
                    end
                    else if (num_done)
                    begin
                        bytes_next = LEN_W'(accum_reg);
                        phase_next = PH_LEN_LF;
                        // empty argument closes here
                        if (accum_reg == '0)
                        begin
                            rslt_valid           = 1'b1;
                            rslt_idx             = cur_reg;
                            rslt.kind            = KIND_EMPTY_ARG;
                            rslt.last_in_arg     = 1'b1;
                            rslt.last_in_command = last_arg;
                            args_next = (args_reg != '0) ? args_reg - CNT_W'(1) : args_reg;
                            cur_next  = cur_reg + ARG_INDEX_BITS'(1);
                        end
                    end
                    else
                    begin
                        accum_next = NUM_W'(value);
                        dig_next   = (dig_reg == DIG_NONE && digit == 4'd0) ? DIG_ZERO
                                                                             : DIG_MORE;
                    end
                end
                PH_LEN_LF:
                begin
                    if (bytes_reg == '0)
                    begin
                        phase_next = PH_TRAILER;
                        skip_next  = 2'd2;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    rslt_valid    = 1'b1;
                    rslt_idx      = cur_reg;
                    rslt.out_byte = in_byte;
                    if (bytes_reg <= LEN_W'(1))
                    begin
                        rslt.last_in_arg     = 1'b1;
                        rslt.last_in_command = last_arg;
                        bytes_next = '0;
                        args_next  = (args_reg != '0) ? args_reg - CNT_W'(1) : args_reg;
                        cur_next   = cur_reg + ARG_INDEX_BITS'(1);
                        phase_next = PH_TRAILER;
                        skip_next  = 2'd2;
                    end
                    else
                    begin
                        bytes_next = bytes_reg - LEN_W'(1);
                    end
                end
                PH_TRAILER:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 2'd0)
                        phase_next = (args_reg != '0) ? PH_ARG_LEAD : PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            dig_reg   <= DIG_NONE;
            accum_reg <= '0;
            args_reg  <= '0;
            cur_reg   <= '0;
            bytes_reg <= '0;
            skip_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            dig_reg   <= dig_next;
            accum_reg <= accum_next;
            args_reg  <= args_next;
            cur_reg   <= cur_next;
            bytes_reg <= bytes_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ----- hdl/rmp_out_queue.sv -----
// two-entry result register with skid slot
module rmp_out_queue
    import rmp_pkg::*;
#(
    parameter int IDX_W = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rslt_t            push_rslt,
    input  logic [IDX_W-1:0] push_idx,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output rslt_t            out_rslt,
    output logic [IDX_W-1:0] out_idx
);

    rslt_t            ent_reg [2];
    logic [IDX_W-1:0] idx_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign out_rslt  = ent_reg[rd_ptr_reg];
    assign out_idx   = idx_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_rslt;
            idx_reg[wr_ptr_reg] <= push_idx;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ----- hdl/resp_multibulk_request_parser_core.sv -----
// top level of the multibulk request parser
//
//   channel   direction   handshake            beat contents
//   in        input       in_valid/in_stall    in_byte
//   out       output      out_valid/out_stall  kind, out_byte, arg_index, last_in_arg,
//                                              last_in_command, error_code
//   cfg       input       cfg_we               cfg_index, cfg_data
//
// one input byte is taken every cycle while in_stall is low
// the parse state machine decides each byte combinationally; a two-entry output queue
// holds results, so input keeps flowing until two results wait behind out_stall
// in_stall is high only while both queue entries are occupied
// reset is asynchronous and active low; no clearing pass is needed after it
module resp_multibulk_request_parser_core
    import rmp_pkg::*;
#(
    parameter int ARG_INDEX_BITS = 20,
    parameter int LENGTH_BITS    = 30
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                in_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                kind,
    output logic [7:0]                out_byte,
    output logic [ARG_INDEX_BITS-1:0] arg_index,
    output logic                      last_in_arg,
    output logic                      last_in_command,
    output logic [1:0]                error_code
);

    logic                      beat;
    logic                      rslt_valid;
    rslt_t                     rslt;
    logic [ARG_INDEX_BITS-1:0] rslt_idx;
    logic                      full;
    rslt_t                     out_rslt;

    assign in_stall = full;
    assign beat     = in_valid && !in_stall;

    // parse state machine
    rmp_parse #(
        .ARG_INDEX_BITS (ARG_INDEX_BITS),
        .LENGTH_BITS    (LENGTH_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .beat       (beat),
        .in_byte    (in_byte),
        .rslt_valid (rslt_valid),
        .rslt       (rslt),
        .rslt_idx   (rslt_idx)
    );

    // output queue
    rmp_out_queue #(
        .IDX_W (ARG_INDEX_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rslt_valid),
        .push_rslt (rslt),
        .push_idx  (rslt_idx),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rslt  (out_rslt),
        .out_idx   (arg_index)
    );

    // output fields
    assign kind            = out_rslt.kind;
    assign out_byte        = out_rslt.out_byte;
    assign last_in_arg     = out_rslt.last_in_arg;
    assign last_in_command = out_rslt.last_in_command;
    assign error_code      = out_rslt.error_code;

endmodule

// ----- hdl/rmp_checker.sv -----
// port-level checks of the multibulk request parser and their binding
module rmp_checker
    import rmp_pkg::*;
#(
    parameter int ARG_INDEX_BITS = 20
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [1:0]                kind,
    input logic [7:0]                out_byte,
    input logic [ARG_INDEX_BITS-1:0] arg_index,
    input logic                      last_in_arg,
    input logic                      last_in_command,
    input logic [1:0]                error_code
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
            && $stable(arg_index) && $stable(error_code))
        else $error("stalled result beat changed");

    // errors carry a code and close nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |->
            error_code != ERR_NONE && !last_in_arg && !last_in_command && out_byte == 8'd0)
        else $error("malformed error beat");

    // non-error beats carry no error code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on a non-error beat");

    // an empty command is a single closing marker at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EMPTY_CMD |->
            last_in_command && !last_in_arg && arg_index == '0)
        else $error("malformed empty command marker");

    // an empty argument always closes its argument
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EMPTY_ARG |-> last_in_arg && out_byte == 8'd0)
        else $error("malformed empty argument marker");

endmodule

bind resp_multibulk_request_parser_core rmp_checker #(
    .ARG_INDEX_BITS (ARG_INDEX_BITS)
) u_rmp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .out_byte        (out_byte),
    .arg_index       (arg_index),
    .last_in_arg     (last_in_arg),
    .last_in_command (last_in_command),
    .error_code      (error_code)
);
